FILE: hdl/cscan_pkg.sv
// ----------------------------------------------------------------------------
// cscan_pkg
// Shared constants, codes and controller/datapath interface types for the
// C-SCAN seek scheduler.
// ----------------------------------------------------------------------------
package cscan_pkg;

    // request store depth and cylinder width
    localparam int MAX_REQUESTS = 32;
    localparam int CYL_BITS     = 16;

    // derived widths
    localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int CCNT_W = CYL_BITS + 1;

    // stream and configuration widths
    localparam int IN_TDATA_W  = ((CYL_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * CYL_BITS + 7) / 8) * 8;
    localparam int TUSER_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = CCNT_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_HEAD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CYLINDER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_DOWN     = 2'd2;

    // register reset values
    localparam logic [CCNT_W-1:0] CYLINDER_COUNT_RESET = CCNT_W'(200);

    // kind of head movement
    typedef enum logic [1:0] {
        KIND_SERVE = 2'd0,
        KIND_END   = 2'd1,
        KIND_WRAP  = 2'd2
    } move_kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       begin_batch;
        logic       scan;
        logic       scan_inc;
        logic       set_split;
        logic       b_init;
        logic       emit;
        move_kind_t kind;
        logic       last;
        logic       clear;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_stop;
        logic a_more;
        logic a_last;
        logic has_b;
        logic b_last;
        logic need_end;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/cscan_sorter.sv
// ----------------------------------------------------------------------------
// cscan_sorter
// Row of request cells kept in ascending order; each new request is
// inserted by shifting the larger entries up one cell.
// ----------------------------------------------------------------------------
module cscan_sorter
    import cscan_pkg::*;
(
    input  logic                clk,
    input  logic                ins_en,
    input  logic [CYL_BITS-1:0] ins_value,
    input  logic [CNT_W-1:0]    fill,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic [CYL_BITS-1:0] rd_data
);

    logic [CYL_BITS-1:0]     cell_reg [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] above;

    genvar i;
    generate
        for (i = 0; i < MAX_REQUESTS; i++)
        begin : g_cell
            // occupied cell holding a value larger than the new request
            assign above[i] = (CNT_W'(i) < fill) && (cell_reg[i] > ins_value);

            if (i == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (ins_en && (above[i] || (CNT_W'(i) == fill)))
                    begin
                        cell_reg[i] <= ins_value;
                    end
                end
            end
            else
            begin : g_rest
                // take the lower neighbor if it moves up, else the new value
                always_ff @(posedge clk)
                begin
                    if (ins_en && (above[i] || (CNT_W'(i) == fill)))
                    begin
                        cell_reg[i] <= above[i-1] ? cell_reg[i-1] : ins_value;
                    end
                end
            end
        end
    endgenerate

    // single read port
    assign rd_data = cell_reg[rd_addr];

endmodule

FILE: hdl/cscan_datapath.sv
// ----------------------------------------------------------------------------
// cscan_datapath
// Configuration registers, sorted request store, sweep index and head
// position, and the registered result stage.
// ----------------------------------------------------------------------------
module cscan_datapath
    import cscan_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write
    input  logic                   cfg_wr,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // request input
    input  logic [CYL_BITS-1:0]    request_cylinder,
    // controller link
    input  dp_cmd_t                cmd,
    output dp_status_t             st,
    // result output
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [CYL_BITS-1:0]    seek_from,
    output logic [CYL_BITS-1:0]    seek_to,
    output logic [CYL_BITS-1:0]    seek_distance,
    output logic [1:0]             move_kind,
    output logic                   dropped_any,
    output logic                   final_step
);

    // configuration registers
    logic [CYL_BITS-1:0] head_reg;
    logic [CCNT_W-1:0]   ccount_reg;
    logic                down_reg;

    // batch state
    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    split_reg;
    logic [CYL_BITS-1:0] cur_reg;

    // result register
    logic                out_valid_reg;
    logic [CYL_BITS-1:0] from_reg, to_reg, dist_reg;
    move_kind_t          kind_reg;
    logic                drop_reg, last_reg;

    logic [CYL_BITS-1:0] top;
    logic [CNT_W-1:0]    addr_full;
    logic [IDX_W-1:0]    rd_addr;
    logic [CYL_BITS-1:0] rd_data;
    logic [CYL_BITS-1:0] step_from, step_to, step_dist;
    logic                ins_en;

    // top cylinder: count of zero acts as one, large counts are capped
    always_comb
    begin
        if (ccount_reg == '0)
        begin
            top = '0;
        end
        else if (ccount_reg[CYL_BITS])
        begin
            top = '1;
        end
        else
        begin
            top = ccount_reg[CYL_BITS-1:0] - CYL_BITS'(1);
        end
    end

    // store access; a downward sweep reads the entry below the index
    assign ins_en    = cmd.load && (count_reg < CNT_W'(MAX_REQUESTS));
    assign addr_full = (down_reg && !cmd.scan) ? (idx_reg - CNT_W'(1)) : idx_reg;
    assign rd_addr   = addr_full[IDX_W-1:0];

    cscan_sorter u_sorter (
        .clk       (clk),
        .ins_en    (ins_en),
        .ins_value (request_cylinder),
        .fill      (count_reg),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // status toward the controller
    always_comb
    begin
        st.scan_stop = (idx_reg == count_reg) ||
                       (down_reg ? (rd_data > head_reg) : (rd_data >= head_reg));
        st.a_more    = down_reg ? (idx_reg != '0) : (idx_reg < count_reg);
        st.a_last    = down_reg ? (idx_reg == CNT_W'(1))
                                : (idx_reg == count_reg - CNT_W'(1));
        st.has_b     = down_reg ? (split_reg < count_reg) : (split_reg != '0);
        st.b_last    = down_reg ? (idx_reg == split_reg + CNT_W'(1))
                                : (idx_reg == split_reg - CNT_W'(1));
        st.need_end  = down_reg ? (cur_reg != '0) : (cur_reg != top);
        st.out_free  = !out_valid_reg || out_ready;
    end

    // endpoints of the movement being issued
    always_comb
    begin
        case (cmd.kind)
            KIND_SERVE:
            begin
                step_from = cur_reg;
                step_to   = rd_data;
            end
            KIND_END:
            begin
                step_from = cur_reg;
                step_to   = down_reg ? '0 : top;
            end
            KIND_WRAP:
            begin
                step_from = down_reg ? '0 : top;
                step_to   = down_reg ? top : '0;
            end
            default:
            begin
                step_from = cur_reg;
                step_to   = cur_reg;
            end
        endcase
    end

    // absolute distance; a wrap reports the top cylinder
    always_comb
    begin
        if (cmd.kind == KIND_WRAP)
        begin
            step_dist = top;
        end
        else if (step_from >= step_to)
        begin
            step_dist = step_from - step_to;
        end
        else
        begin
            step_dist = step_to - step_from;
        end
    end

    // sweep index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.begin_batch)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        else if (cmd.b_init)
        begin
            idx_next = down_reg ? count_reg : '0;
        end
        else if (cmd.emit && (cmd.kind == KIND_SERVE))
        begin
            idx_next = down_reg ? (idx_reg - CNT_W'(1)) : (idx_reg + CNT_W'(1));
        end
    end

    // configuration and batch control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            ccount_reg <= CYLINDER_COUNT_RESET;
            down_reg   <= 1'b0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            idx_reg    <= '0;
            split_reg  <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_START_HEAD:     head_reg   <= cfg_data[CYL_BITS-1:0];
                    REG_CYLINDER_COUNT: ccount_reg <= cfg_data[CCNT_W-1:0];
                    REG_SWEEP_DOWN:     down_reg   <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (ins_en)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.set_split)
            begin
                split_reg <= idx_reg;
            end
            idx_reg <= idx_next;
        end
    end

    // head position
    always_ff @(posedge clk)
    begin
        if (cmd.begin_batch)
        begin
            cur_reg <= head_reg;
        end
        else if (cmd.emit)
        begin
            cur_reg <= step_to;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            from_reg <= step_from;
            to_reg   <= step_to;
            dist_reg <= step_dist;
            kind_reg <= cmd.kind;
            drop_reg <= ovf_reg;
            last_reg <= cmd.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign seek_from     = from_reg;
    assign seek_to       = to_reg;
    assign seek_distance = dist_reg;
    assign move_kind     = kind_reg;
    assign dropped_any   = drop_reg;
    assign final_step    = last_reg;

    // store fill never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REQUESTS))
        else $error("request count beyond capacity");

    // a drop is only recorded with a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CNT_W'(MAX_REQUESTS)))
        else $error("overflow flag set while store not full");

    // the final movement of a batch empties the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> ((count_reg == '0) && !ovf_reg))
        else $error("store not emptied after batch");

endmodule

FILE: hdl/cscan_ctrl.sv
// ----------------------------------------------------------------------------
// cscan_ctrl
// Sequencer for one batch: load requests, find the split point, issue the
// first sweep, the travel to the disk end, the wrap and the second sweep.
// ----------------------------------------------------------------------------
module cscan_ctrl
    import cscan_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_SWEEP_A,
        S_END,
        S_WRAP,
        S_SWEEP_B
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = KIND_SERVE;
        in_ready   = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.begin_batch = 1'b1;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_stop)
                begin
                    cmd.set_split = 1'b1;
                    state_next    = S_SWEEP_A;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_SWEEP_A:
            begin
                if (st.a_more)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit = 1'b1;
                        if (st.a_last && !st.has_b)
                        begin
                            cmd.last   = 1'b1;
                            cmd.clear  = 1'b1;
                            state_next = S_LOAD;
                        end
                    end
                end
                else if (st.has_b)
                begin
                    state_next = S_END;
                end
                else
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_END:
            begin
                cmd.kind = KIND_END;
                if (!st.need_end)
                begin
                    state_next = S_WRAP;
                end
                else if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                cmd.kind = KIND_WRAP;
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.b_init = 1'b1;
                    state_next = S_SWEEP_B;
                end
            end
            S_SWEEP_B:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.b_last)
                    begin
                        cmd.last   = 1'b1;
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // no request is taken while a movement is issued
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.emit)
        else $error("load and emission overlap");

    // a movement is issued only into a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("result register overwritten");

    // after the final movement the block loads again
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == S_LOAD))
        else $error("batch did not return to load");

endmodule

FILE: hdl/cscan_disk_seek_scheduler.sv
// ----------------------------------------------------------------------------
// cscan_disk_seek_scheduler
// C-SCAN disk seek scheduler: collects a batch of cylinder requests and
// emits the head movement sequence when the batch is closed.
// ----------------------------------------------------------------------------
// Loading: one request per cycle while in the load state; each is sorted
// into the store on arrival. Batch of n requests: after the closing request,
// a split search (one store entry per cycle), then one movement per cycle
// while m_axis_tready stays high; leaving the first sweep and a skipped
// travel to the end each take a step that issues no movement.
// Reset: controller, request count, drop flag and output valid cleared,
// configuration to its reset values; store contents undefined, no clearing.
// ----------------------------------------------------------------------------
module cscan_disk_seek_scheduler
    import cscan_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // request_cylinder
    input  logic                   s_axis_tlast,   // batch_end
    // movement stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // seek_from, seek_to, seek_distance
    output logic [TUSER_W-1:0]     m_axis_tuser,   // move_kind, dropped_any
    output logic                   m_axis_tlast,   // final_step
    // configuration write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t             cmd;
    dp_status_t          st;
    logic [CYL_BITS-1:0] seek_from, seek_to, seek_distance;
    logic [1:0]          move_kind;
    logic                dropped_any;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    cscan_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cscan_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .request_cylinder (s_axis_tdata[CYL_BITS-1:0]),
        .cmd              (cmd),
        .st               (st),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .seek_from        (seek_from),
        .seek_to          (seek_to),
        .seek_distance    (seek_distance),
        .move_kind        (move_kind),
        .dropped_any      (dropped_any),
        .final_step       (m_axis_tlast)
    );

    // output packing
    always_comb
    begin
        m_axis_tdata                           = '0;
        m_axis_tdata[CYL_BITS-1:0]             = seek_from;
        m_axis_tdata[2*CYL_BITS-1:CYL_BITS]    = seek_to;
        m_axis_tdata[3*CYL_BITS-1:2*CYL_BITS]  = seek_distance;
        m_axis_tuser                           = {dropped_any, move_kind};
    end

endmodule

FILE: sim/tb_cscan_disk_seek_scheduler.sv
// ----------------------------------------------------------------------------
// tb_cscan_disk_seek_scheduler
// Self-checking testbench for the C-SCAN seek scheduler. Batches of cylinder
// requests are streamed in, a behavioral scheduler inside the bench works out
// the head movements of each batch, and every movement on the output stream
// is compared field by field against that list. Directed batches cover the
// register extremes and corner cases, then random batches run under several
// sender and receiver idle patterns, including a long output stall.
// ----------------------------------------------------------------------------
module tb_cscan_disk_seek_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import cscan_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;

    // one head movement as seen on the output stream
    typedef struct {
        logic [15:0] seek_from;
        logic [15:0] seek_to;
        logic [15:0] seek_distance;
        move_kind_t  move_kind;
        logic        dropped_any;
        logic        final_step;
    } seek_move_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0]     m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // scheduler state mirrored by the bench
    logic [15:0] held_requests [MAX_REQUESTS];
    int          held_count = 0;
    logic        overflow_flag = 1'b0;
    logic [15:0] cfg_start_head = 16'd0;
    logic [16:0] cfg_cyl_count = 17'd200;
    logic        cfg_sweep_down = 1'b0;

    // movements still to come, oldest first
    seek_move_t  pending_moves [$];

    int failures = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    cscan_disk_seek_scheduler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always #5 clk = ~clk;

    // top cylinder for a given cylinder count, zero and oversize counts clamped
    function automatic logic [15:0] top_of(input logic [16:0] count);
        if (count == 17'd0)
            return 16'd0;
        if (count > 17'd65536)
            return 16'hFFFF;
        return 16'(count - 17'd1);
    endfunction

    function automatic seek_move_t make_move(input logic [15:0] from_cyl,
                                             input logic [15:0] to_cyl,
                                             input move_kind_t kind);
        seek_move_t mv;
        mv.seek_from = from_cyl;
        mv.seek_to   = to_cyl;
        // a wrap reports the top cylinder as its distance
        if (kind == KIND_WRAP)
            mv.seek_distance = (from_cyl > to_cyl) ? from_cyl : to_cyl;
        else
            mv.seek_distance = (to_cyl >= from_cyl) ? to_cyl - from_cyl : from_cyl - to_cyl;
        mv.move_kind   = kind;
        mv.dropped_any = overflow_flag;
        mv.final_step  = 1'b0;
        return mv;
    endfunction

    // sort the held requests and queue the c-scan movement sequence
    task automatic plan_batch_moves();
        logic [15:0] sorted [MAX_REQUESTS];
        seek_move_t  moves [2*MAX_REQUESTS+2];
        logic [15:0] top_cyl;
        logic [15:0] head;
        logic [15:0] x;
        int n, i, j, split, k;
        n = held_count;
        k = 0;
        for (i = 0; i < n; i++)
        begin
            x = held_requests[i];
            j = i;
            while (j > 0 && sorted[j-1] > x)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = x;
        end
        top_cyl = top_of(cfg_cyl_count);
        head    = cfg_start_head;
        split   = 0;
        if (!cfg_sweep_down)
        begin
            // upward sweep, then end travel, wrap to zero, rest ascending
            while (split < n && sorted[split] < head)
                split++;
            for (i = split; i < n; i++)
            begin
                moves[k] = make_move(head, sorted[i], KIND_SERVE);
                k++;
                head = sorted[i];
            end
            if (split > 0)
            begin
                if (head != top_cyl)
                begin
                    moves[k] = make_move(head, top_cyl, KIND_END);
                    k++;
                end
                moves[k] = make_move(top_cyl, 16'd0, KIND_WRAP);
                k++;
                head = 16'd0;
                for (i = 0; i < split; i++)
                begin
                    moves[k] = make_move(head, sorted[i], KIND_SERVE);
                    k++;
                    head = sorted[i];
                end
            end
        end
        else
        begin
            // downward sweep, then travel to zero, wrap to top, rest descending
            while (split < n && sorted[split] <= head)
                split++;
            for (i = split; i > 0; i--)
            begin
                moves[k] = make_move(head, sorted[i-1], KIND_SERVE);
                k++;
                head = sorted[i-1];
            end
            if (split < n)
            begin
                if (head != 16'd0)
                begin
                    moves[k] = make_move(head, 16'd0, KIND_END);
                    k++;
                end
                moves[k] = make_move(16'd0, top_cyl, KIND_WRAP);
                k++;
                head = top_cyl;
                for (i = n; i > split; i--)
                begin
                    moves[k] = make_move(head, sorted[i-1], KIND_SERVE);
                    k++;
                    head = sorted[i-1];
                end
            end
        end
        if (k > 0)
            moves[k-1].final_step = 1'b1;
        for (i = 0; i < k; i++)
            pending_moves = {pending_moves, moves[i]};
        held_count    = 0;
        overflow_flag = 1'b0;
    endtask

    // send one request, idling at random first
    task automatic send_request(input logic [15:0] cyl, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(cyl);
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // transaction taken at this edge
        if (held_count < MAX_REQUESTS)
        begin
            held_requests[held_count] = cyl;
            held_count++;
        end
        else
            overflow_flag = 1'b1;
        if (last)
            plan_batch_moves();
    endtask

    // hold the request stream until every planned movement has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_moves.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_START_HEAD:     cfg_start_head = value[15:0];
            REG_CYLINDER_COUNT: cfg_cyl_count  = value;
            REG_SWEEP_DOWN:     cfg_sweep_down = value[0];
            default: ;
        endcase
    endtask

    // reprogram all registers once the block has gone quiet
    task automatic apply_config(input logic [15:0] start_head,
                                input logic [16:0] count,
                                input logic down);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(REG_START_HEAD, CFG_DATA_W'(start_head));
        write_register(REG_CYLINDER_COUNT, CFG_DATA_W'(count));
        write_register(REG_SWEEP_DOWN, CFG_DATA_W'(down));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            failures++;
        end
    endtask

    // compare each movement transaction with the oldest planned one
    always @(posedge clk)
    begin : check_movement
        seek_move_t exp_move;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_moves.size() == 0)
            begin
                $error("movement with none expected: from %0d to %0d",
                       m_axis_tdata[15:0], m_axis_tdata[31:16]);
                failures++;
            end
            else
            begin
                exp_move = pending_moves.pop_front();
                check_field("seek_from", 32'(exp_move.seek_from),
                            32'(m_axis_tdata[15:0]));
                check_field("seek_to", 32'(exp_move.seek_to),
                            32'(m_axis_tdata[31:16]));
                check_field("seek_distance", 32'(exp_move.seek_distance),
                            32'(m_axis_tdata[47:32]));
                check_field("move_kind", 32'(exp_move.move_kind),
                            32'(m_axis_tuser[1:0]));
                check_field("dropped_any", 32'(exp_move.dropped_any),
                            32'(m_axis_tuser[2]));
                check_field("final_step", 32'(exp_move.final_step),
                            32'(m_axis_tlast));
            end
        end
    end

    // reset register values, requests inside and beyond the top cylinder
    task automatic test_reset_defaults();
        send_request(16'd50, 1'b0);
        send_request(16'd10, 1'b0);
        send_request(16'd250, 1'b0);
        send_request(16'd199, 1'b0);
        send_request(16'd0, 1'b1);
    endtask

    // register extremes, duplicates, head on a request and on the top
    task automatic test_directed_cases();
        // upward, head on a request, duplicates, end travel skipped at top
        apply_config(16'd100, 17'd200, 1'b0);
        send_request(16'd150, 1'b0);
        send_request(16'd20, 1'b0);
        send_request(16'd100, 1'b0);
        send_request(16'd100, 1'b0);
        send_request(16'd199, 1'b1);
        // downward with travel to zero, wrap, request beyond the top
        apply_config(16'd100, 17'd200, 1'b1);
        send_request(16'd100, 1'b0);
        send_request(16'd30, 1'b0);
        send_request(16'd180, 1'b0);
        send_request(16'hFFFF, 1'b1);
        // zero cylinder count acts as one cylinder
        apply_config(16'd0, 17'd0, 1'b1);
        send_request(16'd0, 1'b0);
        send_request(16'd5, 1'b1);
        // oversize count capped, head at the very top
        apply_config(16'hFFFF, 17'h1FFFF, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd1, 1'b1);
        // single request, full-size disk, downward from zero
        apply_config(16'd0, 17'd65536, 1'b1);
        send_request(16'hFFFF, 1'b1);
        // alternating bit patterns
        apply_config(16'd12345, 17'd1000, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hAAAA, 1'b0);
        send_request(16'h5555, 1'b1);
    endtask

    // long output stall while an oversize batch and a second batch come in
    task automatic test_full_store_under_backpressure();
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(16'd30000, 17'd65536, 1'b0);
        hold_requests <= hold_requests + 1;
        for (i = 0; i < 36; i++)
            send_request(16'($urandom), i == 35);
        for (i = 0; i < 12; i++)
            send_request(16'($urandom), i == 11);
        wait_drained();
    endtask

    // random batches under the given idle pattern
    task automatic test_random_batches(input int send_pct, input int recv_pct,
                                       input int budget);
        int sent, len, r, i;
        logic [16:0] count_val;
        logic [15:0] start_val;
        logic [15:0] top_cyl;
        logic [15:0] cyl;
        logic [15:0] prev;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        prev = 16'd0;
        while (sent < budget)
        begin
            // occasional new register setting between batches
            if ($urandom_range(99) < 30)
            begin
                case ($urandom_range(9))
                    0:       count_val = 17'd0;
                    1:       count_val = 17'd1;
                    2:       count_val = 17'd65536;
                    3:       count_val = 17'h1FFFF;
                    4:       count_val = 17'($urandom);
                    default: count_val = 17'($urandom_range(2, 4000));
                endcase
                top_cyl = top_of(count_val);
                case ($urandom_range(9))
                    0:       start_val = 16'd0;
                    1:       start_val = 16'hFFFF;
                    2:       start_val = top_cyl;
                    3:       start_val = 16'($urandom);
                    default: start_val = 16'($urandom_range(0, top_cyl));
                endcase
                apply_config(start_val, count_val, 1'($urandom_range(1)));
            end
            top_cyl = top_of(cfg_cyl_count);
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(1, 8);
            else if (r < 92)
                len = $urandom_range(9, MAX_REQUESTS);
            else
                len = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 8);
            for (i = 0; i < len; i++)
            begin
                r = $urandom_range(99);
                if (r < 55)
                    cyl = 16'($urandom_range(0, top_cyl));
                else if (r < 70)
                    cyl = cfg_start_head + 16'($urandom_range(0, 4)) - 16'd2;
                else if (r < 82 && i > 0)
                    cyl = prev;
                else if (r < 88)
                    cyl = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
                else
                    cyl = 16'($urandom);
                send_request(cyl, i == len - 1);
                prev = cyl;
            end
            sent += len;
        end
        wait_drained();
    endtask

    // watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL cscan_disk_seek_scheduler");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_full_store_under_backpressure();
        test_random_batches(24, 80, 120);
        test_random_batches(80, 24, 120);
        test_random_batches(0, 0, 120);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_moves.size() != 0)
            failures++;
        if (failures == 0)
            $display("PASS cscan_disk_seek_scheduler");
        else
            $display("FAIL cscan_disk_seek_scheduler");
        $finish;
    end

endmodule

FILE: sim.f
hdl/cscan_pkg.sv
hdl/cscan_sorter.sv
hdl/cscan_datapath.sv
hdl/cscan_ctrl.sv
hdl/cscan_disk_seek_scheduler.sv
sim/tb_cscan_disk_seek_scheduler.sv
